[rtl/swmm_pkg.sv]
// Shared constants and types of the sliding window minimum/maximum block.
package swmm_pkg;

  localparam int WINDOW_MAX   = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int WIN_W        = 11;
  localparam int POS_MOD      = 2 * WINDOW_MAX;
  localparam int POS_W        = $clog2(POS_MOD);
  localparam int IDX_W        = $clog2(WINDOW_MAX);
  localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
  localparam int QDEPTH       = 2;
  localparam int Q_IDX_W      = $clog2(QDEPTH);
  localparam int Q_CNT_W      = $clog2(QDEPTH + 1);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // One classified word handed from the front to the back.
  typedef struct packed {
    sample_t          sample;
    logic             clear;
    logic [POS_W-1:0] now;
    logic [CNT_W-1:0] win;
    logic             emit;
  } job_t;

  // Command from the back sequencer to both deque units.
  typedef struct packed {
    logic             start;
    logic             clear;
    sample_t          sample;
    logic [POS_W-1:0] now;
    logic [CNT_W-1:0] win;
  } deq_cmd_t;

  // Status of one deque unit.
  typedef struct packed {
    logic    busy;
    sample_t head_val;
  } deq_stat_t;

endpackage

[rtl/swmm_queue.sv]
// Short queue of classified words between the front and the back.
module swmm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swmm_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output swmm_pkg::job_t rd_job
);
  import swmm_pkg::*;

  job_t               ent_r [QDEPTH];
  logic [Q_IDX_W-1:0] wp_r, wp_nxt;
  logic [Q_IDX_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_job  = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == Q_IDX_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == Q_IDX_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= wr_job;
    end
  end

endmodule

[rtl/swmm_front.sv]
// Front end: window size register, position and fill tracking, word classification.
module swmm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [swmm_pkg::WIN_W-1:0] cfg_wr_data,
  input  logic                       in_push,
  output logic                       in_full,
  input  swmm_pkg::sample_t          in_sample,
  input  logic                       in_first_sample,
  input  logic                       q_full,
  output logic                       q_push,
  output swmm_pkg::job_t             q_job
);
  import swmm_pkg::*;

  logic [WIN_W-1:0] win_cfg_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] fill_base;
  logic [CNT_W-1:0] win_eff;
  logic [POS_W-1:0] now;
  logic             accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;

  always_comb begin
    // A zero size acts as one, an oversized one is clamped.
    if (win_cfg_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (int'(win_cfg_r) > WINDOW_MAX) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = CNT_W'(win_cfg_r);
    end

    now       = in_first_sample ? '0 : pos_r;
    pos_nxt   = (now == POS_W'(POS_MOD - 1)) ? '0 : now + 1'b1;
    fill_base = in_first_sample ? '0 : fill_r;
    fill_nxt  = (fill_base < CNT_W'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;

    q_job.sample = in_sample;
    q_job.clear  = in_first_sample;
    q_job.now    = now;
    q_job.win    = win_eff;
    q_job.emit   = (fill_nxt >= win_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_RESET;
      pos_r     <= '0;
      fill_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_cfg_r <= cfg_wr_data;
      end
      if (accept) begin
        pos_r  <= pos_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

endmodule

[rtl/swmm_deque.sv]
// One monotonic deque: ring memory of (value, position) entries and its step sequencer.
module swmm_deque (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                is_max,
  input  swmm_pkg::deq_cmd_t  cmd,
  output swmm_pkg::deq_stat_t stat
);
  import swmm_pkg::*;

  typedef struct packed {
    sample_t          val;
    logic [POS_W-1:0] pos;
  } entry_t;

  entry_t           mem [WINDOW_MAX];
  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sample_t          v_r;
  logic [POS_W-1:0] now_r;
  logic [CNT_W-1:0] win_r;
  entry_t           rh_r, rt_r, wd_r, wd;
  logic             byp_h_r, byp_t_r;
  entry_t           head_e, tail_e;
  logic [POS_W-1:0] age;
  logic             dominated, drop, pop, push;
  logic [IDX_W-1:0] wa, ra_h, ra_t;

  function automatic logic [IDX_W-1:0] idx_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
    logic [IDX_W:0] s;
    s = (IDX_W+1)'(a) + (IDX_W+1)'(b);
    if (s >= (IDX_W+1)'(WINDOW_MAX)) begin
      s = s - (IDX_W+1)'(WINDOW_MAX);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(WINDOW_MAX - 1) : a - 1'b1;
  endfunction

  always_comb begin
    // Reads are addressed from the next head and tail, so the registered data
    // always matches the current ones; a write in the same cycle is forwarded.
    head_e = byp_h_r ? wd_r : rh_r;
    tail_e = byp_t_r ? wd_r : rt_r;

    if (now_r >= head_e.pos) begin
      age = now_r - head_e.pos;
    end else begin
      age = now_r + POS_W'(POS_MOD) - head_e.pos;
    end

    dominated = is_max ? ($signed(tail_e.val) <= $signed(v_r))
                       : ($signed(tail_e.val) >= $signed(v_r));

    drop = busy_r && (cnt_r != '0) && (age >= POS_W'(win_r));
    pop  = busy_r && !drop && (cnt_r != '0) && dominated;
    push = busy_r && !drop && !pop;

    busy_nxt = busy_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (!busy_r) begin
      if (cmd.start) begin
        busy_nxt = 1'b1;
        if (cmd.clear) begin
          head_nxt = '0;
          cnt_nxt  = '0;
        end
      end
    end else if (drop) begin
      head_nxt = idx_add(head_r, CNT_W'(1));
      cnt_nxt  = cnt_r - 1'b1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt  = cnt_r + 1'b1;
      busy_nxt = 1'b0;
    end

    wa     = idx_add(head_r, cnt_r);
    wd.val = v_r;
    wd.pos = now_r;
    ra_h   = head_nxt;
    ra_t   = idx_dec(idx_add(head_nxt, cnt_nxt));
  end

  assign stat.busy     = busy_r;
  assign stat.head_val = head_e.val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && cmd.start) begin
      v_r   <= cmd.sample;
      now_r <= cmd.now;
      win_r <= cmd.win;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wa] <= wd;
    end
    rh_r    <= mem[ra_h];
    rt_r    <= mem[ra_t];
    byp_h_r <= push && (ra_h == wa);
    byp_t_r <= push && (ra_t == wa);
    wd_r    <= wd;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_MAX))
    else $error("deque count exceeds ring depth");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("deque started while busy");

  a_push_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !busy_r && cnt_r != '0)
    else $error("deque push did not end the step with a live entry");
`endif

endmodule

[rtl/swmm_back.sv]
// Back end: takes classified words, runs both deques and holds the result word.
module swmm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  swmm_pkg::job_t      q_job,
  output logic                q_pop,
  output swmm_pkg::deq_cmd_t  cmd,
  input  swmm_pkg::deq_stat_t min_st,
  input  swmm_pkg::deq_stat_t max_st,
  input  logic                out_pop,
  output logic                out_empty,
  output swmm_pkg::sample_t   out_window_min,
  output swmm_pkg::sample_t   out_window_max
);
  import swmm_pkg::*;

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t state_r;
  logic    emit_r;
  logic    out_valid_r;
  sample_t out_min_r, out_max_r;
  logic    both_idle, out_free, finish, can_start;

  assign both_idle = !min_st.busy && !max_st.busy;
  assign out_free  = !out_valid_r || out_pop;
  assign finish    = (state_r == B_RUN) && both_idle && (!emit_r || out_free);
  // The next word starts in the same cycle the previous one finishes.
  assign can_start = !q_empty && ((state_r == B_IDLE) || finish);
  assign q_pop     = can_start;

  assign cmd.start  = can_start;
  assign cmd.clear  = q_job.clear;
  assign cmd.sample = q_job.sample;
  assign cmd.now    = q_job.now;
  assign cmd.win    = q_job.win;

  assign out_empty      = !out_valid_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (can_start) begin
            state_r <= B_RUN;
            emit_r  <= q_job.emit;
          end
        end
        B_RUN: begin
          if (can_start) begin
            emit_r <= q_job.emit;
          end else if (finish) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
      if (finish && emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish && emit_r) begin
      out_min_r <= min_st.head_val;
      out_max_r <= max_st.head_val;
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    can_start |=> min_st.busy && max_st.busy)
    else $error("deque units did not take the started word");

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_IDLE |-> both_idle)
    else $error("deque unit busy while sequencer idle");
`endif

endmodule

[rtl/sliding_window_min_max.sv]
// Each accepted word runs a step sequence in both deques: head drops, tail pops, then one push;
// each deque does one memory step (drop, pop or push) per cycle. A word that emits waits for a free
// result register; the deques take the next word only once both are through with the last one.
// A two-word queue parts the front from the deques, and a result register parts the output.
// Reset (synchronous, active low) empties both deques, clears position and fill counts and
// sets the window size to 3; the deque memories are not cleared and need no clearing pass.
module sliding_window_min_max (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [swmm_pkg::WIN_W-1:0] cfg_wr_data,
  input  logic                       in_push,
  output logic                       in_full,
  input  swmm_pkg::sample_t          in_sample,
  input  logic                       in_first_sample,
  output logic                       out_empty,
  input  logic                       out_pop,
  output swmm_pkg::sample_t          out_window_min,
  output swmm_pkg::sample_t          out_window_max
);
  import swmm_pkg::*;

  logic      q_full, q_push, q_empty, q_pop;
  job_t      q_wr_job, q_rd_job;
  deq_cmd_t  cmd;
  deq_stat_t min_st, max_st;

  swmm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_sample       (in_sample),
    .in_first_sample (in_first_sample),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_wr_job)
  );

  swmm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_rd_job)
  );

  swmm_deque u_min_deque (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b0),
    .cmd    (cmd),
    .stat   (min_st)
  );

  swmm_deque u_max_deque (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b1),
    .cmd    (cmd),
    .stat   (max_st)
  );

  swmm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (q_rd_job),
    .q_pop          (q_pop),
    .cmd            (cmd),
    .min_st         (min_st),
    .max_st         (max_st),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_window_min (out_window_min),
    .out_window_max (out_window_max)
  );

endmodule

[tb/tb_sliding_window_min_max.sv]
// Self-checking testbench: sliding window min/max against a two-deque predictor.
`timescale 1ns / 1ps

module tb_sliding_window_min_max;
  import swmm_pkg::*;

  localparam int DQ_MIN = 0;
  localparam int DQ_MAX = 1;
  localparam int RX_STREAM = 0;
  localparam int RX_LIGHT  = 1;
  localparam int RX_HEAVY  = 2;
  localparam int NUM_PHASES  = 11;
  localparam int SETTLE_CYC  = 6500;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP   = 40;
  localparam int MAX_WORDS   = 1024;

  typedef struct {
    sample_t value;
    logic    first;
  } sample_word_t;

  typedef struct {
    sample_t lo;
    sample_t hi;
  } minmax_t;

  typedef struct {
    int win;
    int len;
    bit fresh;
    int first_odds;
    bit ramp;
    bit split;
  } phase_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [WIN_W-1:0] cfg_wr_data = '0;
  logic             in_push = 1'b0;
  logic             in_full;
  sample_t          in_sample = '0;
  logic             in_first_sample = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  sample_t          out_window_min;
  sample_t          out_window_max;

  sliding_window_min_max dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample      (in_sample),
    .in_first_sample(in_first_sample),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_window_min (out_window_min),
    .out_window_max (out_window_max)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: two monotonic deques, positions and fill count.
  sample_t          dq_val [2][WINDOW_MAX];
  int               dq_pos [2][WINDOW_MAX];
  int               dq_head [2];
  int               dq_cnt [2];
  int               pos_count = 0;
  int               fill_cnt = 0;
  logic [WIN_W-1:0] window_reg = WIN_RESET;

  // Pending words and expected results, each a list with read and write indexes.
  sample_word_t sample_queue [MAX_WORDS];
  int           sq_wr = 0;
  int           sq_rd = 0;
  minmax_t      expected_minmax [MAX_WORDS];
  int           ex_wr = 0;
  int           ex_rd = 0;

  int err_count = 0;
  int samples_in = 0;
  int results_checked = 0;
  int seq_starts = 0;
  int cfg_writes = 0;

  int burst_left = 8;
  int gap_left = 0;
  int stall_left = 0;
  int rx_mode = RX_STREAM;
  int rx_cycle = 0;

  sample_t last_sample = '0;
  int      run_step = 1;

  task automatic report_error(string msg);
    if (err_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int eff_window(logic [WIN_W-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return int'(w);
  endfunction

  function automatic void deque_update(int d, sample_t v, int now, int win);
    int t;
    bit keep;
    while (dq_cnt[d] > 0 && ((now + POS_MOD - dq_pos[d][dq_head[d]]) % POS_MOD) >= win) begin
      dq_head[d] = (dq_head[d] + 1) % WINDOW_MAX;
      dq_cnt[d]--;
    end
    // Ties are popped: an equal newcomer takes the place of the tail.
    while (dq_cnt[d] > 0) begin
      t = (dq_head[d] + dq_cnt[d] - 1) % WINDOW_MAX;
      keep = (d == DQ_MAX) ? (dq_val[d][t] > v) : (dq_val[d][t] < v);
      if (keep) break;
      dq_cnt[d]--;
    end
    t = (dq_head[d] + dq_cnt[d]) % WINDOW_MAX;
    dq_val[d][t] = v;
    dq_pos[d][t] = now;
    dq_cnt[d]++;
  endfunction

  function automatic bit slide_window(sample_t v, logic first, output sample_t lo,
                                      output sample_t hi);
    int win;
    int now;
    win = eff_window(window_reg);
    if (first) begin
      dq_head[DQ_MIN] = 0;
      dq_head[DQ_MAX] = 0;
      dq_cnt[DQ_MIN] = 0;
      dq_cnt[DQ_MAX] = 0;
      pos_count = 0;
      fill_cnt = 0;
    end
    now = pos_count;
    deque_update(DQ_MIN, v, now, win);
    deque_update(DQ_MAX, v, now, win);
    pos_count = (now + 1) % POS_MOD;
    if (fill_cnt < WINDOW_MAX) fill_cnt++;
    lo = dq_val[DQ_MIN][dq_head[DQ_MIN]];
    hi = dq_val[DQ_MAX][dq_head[DQ_MAX]];
    return fill_cnt >= win;
  endfunction

  function automatic phase_t phase_cfg(int p);
    phase_t ph;
    ph = '{win: 3, len: 40, fresh: 1'b0, first_odds: 0, ramp: 1'b0, split: 1'b0};
    case (p)
      0:  ph = '{win: 0,    len: 30,  fresh: 1'b1, first_odds: 25, ramp: 1'b0, split: 1'b0};
      1:  ph = '{win: 1,    len: 20,  fresh: 1'b0, first_odds: 25, ramp: 1'b0, split: 1'b0};
      2:  ph = '{win: 2,    len: 30,  fresh: 1'b1, first_odds: 20, ramp: 1'b0, split: 1'b0};
      3:  ph = '{win: 5,    len: 40,  fresh: 1'b0, first_odds: 30, ramp: 1'b0, split: 1'b0};
      4:  ph = '{win: 17,   len: 60,  fresh: 1'b1, first_odds: 40, ramp: 1'b0, split: 1'b1};
      5:  ph = '{win: 150,  len: 200, fresh: 1'b1, first_odds: 0,  ramp: 1'b1, split: 1'b0};
      6:  ph = '{win: 2047, len: 30,  fresh: 1'b0, first_odds: 0,  ramp: 1'b0, split: 1'b0};
      7:  ph = '{win: 4,    len: 40,  fresh: 1'b0, first_odds: 0,  ramp: 1'b0, split: 1'b0};
      8:  ph = '{win: 300,  len: 60,  fresh: 1'b0, first_odds: 0,  ramp: 1'b0, split: 1'b0};
      9:  ph = '{win: 64,   len: 60,  fresh: 1'b1, first_odds: 60, ramp: 1'b0, split: 1'b0};
      default: ph = '{win: 3, len: 40, fresh: 1'b0, first_odds: 15, ramp: 1'b0, split: 1'b0};
    endcase
    return ph;
  endfunction

  // Mix of full-range values, a narrow band full of ties, extremes and monotonic runs.
  function automatic sample_t next_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      last_sample = sample_t'($urandom);
    end else if (pick <= 5) begin
      last_sample = sample_t'($urandom_range(0, 6)) - 3;
    end else if (pick == 6) begin
      case ($urandom_range(0, 3))
        0: last_sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        1: last_sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        2: last_sample = '0;
        default: last_sample = '1;
      endcase
    end else begin
      if ($urandom_range(0, 15) == 0) run_step = -run_step;
      last_sample = last_sample + sample_t'(run_step * int'($urandom_range(0, 50)));
    end
    return last_sample;
  endfunction

  task automatic add_word(sample_t v, logic first);
    if (sq_wr >= MAX_WORDS) begin
      report_error("pending word list overflow");
    end else begin
      sample_queue[sq_wr] = '{value: v, first: first};
      sq_wr++;
    end
  endtask

  task automatic wait_idle();
    while (sq_wr != sq_rd || ex_wr != ex_rd) @(posedge clk);
  endtask

  task automatic write_window(int w);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= WIN_W'(w);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = WIN_W'(w);
    cfg_writes++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    sample_word_t w;
    sample_t lo;
    sample_t hi;
    bit go;
    if (rst_n) begin
      if (in_push && !in_full) begin
        w = sample_queue[sq_rd];
        sq_rd++;
        if (slide_window(w.value, w.first, lo, hi)) begin
          expected_minmax[ex_wr] = '{lo: lo, hi: hi};
          ex_wr++;
        end
        samples_in++;
        if (w.first) seq_starts++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          burst_left = $urandom_range(1, 24);
        end
      end else if (!in_push && gap_left > 0) begin
        gap_left--;
      end
      go = (gap_left == 0) && (sq_wr > sq_rd);
      in_push <= go;
      if (go) begin
        in_sample <= sample_queue[sq_rd].value;
        in_first_sample <= sample_queue[sq_rd].first;
      end
    end
  end

  // Receiver: checks each popped word and stalls in modes that change over time.
  always @(posedge clk) begin
    minmax_t want;
    bit pop_next;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (ex_wr == ex_rd) begin
          report_error($sformatf("unexpected result min=%0d max=%0d",
                                 out_window_min, out_window_max));
        end else begin
          want = expected_minmax[ex_rd];
          ex_rd++;
          if (out_window_min !== want.lo)
            report_error($sformatf("window_min got %0d want %0d", out_window_min, want.lo));
          if (out_window_max !== want.hi)
            report_error($sformatf("window_max got %0d want %0d", out_window_max, want.hi));
          results_checked++;
        end
      end
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(RX_STREAM, RX_HEAVY);
      if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
        if (rx_mode == RX_LIGHT && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 6);
        else if (rx_mode == RX_HEAVY && $urandom_range(0, 1) == 0)
          stall_left = $urandom_range(1, 16);
      end
      out_pop <= pop_next;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    phase_t  ph;
    sample_t ramp_val;
    logic    first;
    dq_head[DQ_MIN] = 0;
    dq_head[DQ_MAX] = 0;
    dq_cnt[DQ_MIN] = 0;
    dq_cnt[DQ_MAX] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset window of three; the first words come before any
    // first-of-sequence flag, so the block must act as if a sequence had just begun.
    add_word(32'sd5, 1'b0);
    add_word(-32'sd7, 1'b0);
    add_word(32'sd5, 1'b0);
    add_word(32'sd5, 1'b0);
    add_word(32'sh7FFFFFFF, 1'b0);
    add_word(32'sh80000000, 1'b0);
    add_word(32'sd0, 1'b0);
    add_word(-32'sd1, 1'b0);
    add_word(-32'sd1, 1'b0);
    add_word(-32'sd1, 1'b0);
    add_word(32'sd100, 1'b1);
    add_word(32'sd100, 1'b0);
    add_word(32'sd99, 1'b0);
    add_word(32'sd101, 1'b0);
    add_word(32'sh80000000, 1'b1);
    add_word(32'sh80000000, 1'b0);
    add_word(32'sh7FFFFFFF, 1'b0);
    add_word(32'sh7FFFFFFF, 1'b0);
    add_word(32'sh55555555, 1'b0);
    add_word(32'shAAAAAAAA, 1'b0);
    add_word(32'sd0, 1'b1);
    add_word(32'sd0, 1'b1);
    add_word(-32'sd3, 1'b1);
    add_word(32'sd8, 1'b0);
    add_word(32'sd2, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = phase_cfg(p);
      wait_idle();
      // Words that give no result may still be inside the block.
      repeat (SETTLE_CYC) @(posedge clk);
      write_window(ph.win);
      ramp_val = -32'sd1000000;
      for (int i = 0; i < ph.len; i++) begin
        first = (ph.fresh && i == 0) ||
                (ph.first_odds > 0 && $urandom_range(1, ph.first_odds) == 1);
        if (ph.ramp) begin
          // Long rise builds a deep minimum deque; the fall then empties it at once.
          if (i < 120) ramp_val = ramp_val + sample_t'($urandom_range(1, 1000));
          else ramp_val = ramp_val - sample_t'($urandom_range(1, 1000));
          add_word(ramp_val, first);
        end else begin
          add_word(next_sample(), first);
        end
        // Mid-phase hold: wait until every pending word is sent and every expected result checked.
        if (ph.split && i == ph.len / 2) wait_idle();
      end
    end

    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (ex_wr != ex_rd)
      report_error($sformatf("%0d results never arrived", ex_wr - ex_rd));
    $display("Covered %0d samples in %0d sequences, %0d results checked, %0d window writes",
             samples_in, seq_starts, results_checked, cfg_writes);
    $display("Windows from zero to beyond the maximum, with ties, extremes and long ramps");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sliding_window_min_max.f]
rtl/swmm_pkg.sv
rtl/swmm_queue.sv
rtl/swmm_front.sv
rtl/swmm_deque.sv
rtl/swmm_back.sv
rtl/sliding_window_min_max.sv
tb/tb_sliding_window_min_max.sv
